// ===== rtl/sccb_master_bit_sequencer_defines.svh =====
// assertion macros used by the sequencer back end
`ifndef SCCB_MASTER_BIT_SEQUENCER_DEFINES_SVH
`define SCCB_MASTER_BIT_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define SCCB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SCCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/sccb_pkg.sv =====
package sccb_pkg;

	typedef enum logic [2:0] {
		CMD_START = 3'd0,
		CMD_STOP  = 3'd1,
		CMD_WRITE = 3'd2,
		CMD_READ  = 3'd3,
		CMD_ACK   = 3'd4,
		CMD_NACK  = 3'd5
	} cmd_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] tx_byte;
		logic [7:0] rx_bits;
		logic       rx_ack;
	} cmd_item_t;

	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam logic [4:0] HOLD_WAIT   = 5'd2;
	localparam logic [4:0] HOLD_BASE   = 5'd10;
	localparam logic [4:0] HOLD_RDLOW  = 5'd11;
	localparam logic [4:0] HOLD_BIT    = 5'd12;
	localparam logic [4:0] HOLD_WRLOW  = 5'd14;
	localparam logic [4:0] HOLD_LONG   = 5'd20;
	localparam logic [2:0] LAST_BIT    = 3'd7;

	function automatic logic func_ok(input logic [2:0] f);
		logic ok;
		ok = (f == CMD_START) || (f == CMD_STOP) || (f == CMD_WRITE) ||
			(f == CMD_READ) || (f == CMD_ACK) || (f == CMD_NACK);
		return ok;
	endfunction

endpackage

// ===== rtl/sccb_cmd_if.sv =====
interface sccb_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic [7:0] tx_byte;
	logic [7:0] rx_bits;
	logic       rx_ack;

	modport source (output valid, func, tx_byte, rx_bits, rx_ack, input ready);
	modport sink (input valid, func, tx_byte, rx_bits, rx_ack, output ready);
endinterface

// ===== rtl/sccb_phase_if.sv =====
interface sccb_phase_if;
	logic       valid;
	logic       ready;
	logic       scl;
	logic       sda;
	logic [4:0] hold_us;
	logic       sampled;
	logic [7:0] rx_data;
	logic       ack;
	logic       last;

	modport source (output valid, scl, sda, hold_us, sampled, rx_data, ack, last, input ready);
	modport sink (input valid, scl, sda, hold_us, sampled, rx_data, ack, last, output ready);
endinterface

// ===== rtl/sccb_front.sv =====
module sccb_front import sccb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	sccb_cmd_if.sink   cmd,
	output logic       push,
	output cmd_item_t  push_item,
	input  logic       full
);

	logic      valid_s1;
	cmd_item_t item_s1;

	assign cmd.ready = !valid_s1 || !full;
	assign push      = valid_s1 && !full;
	assign push_item = item_s1;

	// unused codes are taken and dropped here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid && func_ok(cmd.func);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1.cmd     <= cmd_t'(cmd.func);
			item_s1.tx_byte <= cmd.tx_byte;
			item_s1.rx_bits <= cmd.rx_bits;
			item_s1.rx_ack  <= cmd.rx_ack;
		end
	end

endmodule

// ===== rtl/sccb_fifo.sv =====
module sccb_fifo import sccb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_item_t push_item,
	output logic      full,
	input  logic      pop,
	output logic      q_valid,
	output cmd_item_t q_item
);

	cmd_item_t        ent_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   cnt_q;

	assign full    = (cnt_q == QCW'(QDEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_item  = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/sccb_back.sv =====
`include "sccb_master_bit_sequencer_defines.svh"

module sccb_back import sccb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  cmd_item_t    q_item,
	output logic         pop,
	sccb_phase_if.source phase
);

	cmd_item_t  cur_q;
	logic       active_q;
	logic [1:0] stp_q;
	logic [2:0] bit_q;
	logic [1:0] sub_q;
	logic       scl_q;
	logic       sda_q;

	logic       ovalid_q;
	logic       oscl_q;
	logic       osda_q;
	logic [4:0] ohold_q;
	logic       osmp_q;
	logic [7:0] orxd_q;
	logic       oack_q;
	logic       olast_q;

	logic       ph_scl;
	logic       ph_sda;
	logic [4:0] ph_hold;
	logic       ph_smp;
	logic [7:0] ph_rxd;
	logic       ph_ack;
	logic       ph_last;
	logic       loop_cmd;
	logic [1:0] sub_end;
	logic       fire;

	assign loop_cmd = (cur_q.cmd == CMD_WRITE) || (cur_q.cmd == CMD_READ);
	assign sub_end  = (cur_q.cmd == CMD_WRITE) ? 2'd2 : 2'd1;

	always_comb begin
		ph_scl  = scl_q;
		ph_sda  = sda_q;
		ph_hold = HOLD_BASE;
		ph_smp  = 1'b0;
		ph_rxd  = '0;
		ph_ack  = 1'b0;
		ph_last = 1'b0;
		case (cur_q.cmd)
			CMD_START: begin
				case (stp_q)
					2'd0: begin
						ph_sda  = 1'b1;
						ph_hold = HOLD_LONG;
					end
					2'd1: begin
						ph_scl  = 1'b1;
						ph_hold = HOLD_BIT;
					end
					2'd2: begin
						ph_sda  = 1'b0;
						ph_hold = HOLD_BIT;
					end
					default: begin
						ph_scl  = 1'b0;
						ph_last = 1'b1;
					end
				endcase
			end
			CMD_STOP: begin
				case (stp_q)
					2'd0: ph_sda = 1'b0;
					2'd1: ph_scl = 1'b1;
					default: begin
						ph_sda  = 1'b1;
						ph_last = 1'b1;
					end
				endcase
			end
			CMD_WRITE: begin
				if (stp_q == 2'd0) begin
					ph_hold = HOLD_WAIT;
				end else begin
					case (sub_q)
						2'd0: begin
							ph_sda  = cur_q.tx_byte[~bit_q];
							ph_hold = HOLD_BIT;
						end
						2'd1: begin
							ph_scl  = 1'b1;
							ph_hold = HOLD_BIT;
						end
						default: begin
							ph_scl  = 1'b0;
							ph_last = (bit_q == LAST_BIT);
							ph_hold = ph_last ? HOLD_BIT : HOLD_WRLOW;
						end
					endcase
				end
			end
			CMD_READ: begin
				if (stp_q == 2'd0) begin
					ph_sda = 1'b1;
				end else if (sub_q == 2'd0) begin
					ph_scl  = 1'b1;
					ph_smp  = 1'b1;
					ph_hold = HOLD_LONG;
				end else begin
					ph_scl  = 1'b0;
					ph_hold = HOLD_RDLOW;
					ph_last = (bit_q == LAST_BIT);
					ph_rxd  = ph_last ? cur_q.rx_bits : 8'd0;
				end
			end
			CMD_ACK: begin
				case (stp_q)
					2'd0: ph_sda = 1'b1;
					2'd1: begin
						ph_scl  = 1'b1;
						ph_smp  = 1'b1;
						ph_hold = HOLD_LONG;
					end
					default: begin
						ph_scl  = 1'b0;
						ph_ack  = cur_q.rx_ack;
						ph_last = 1'b1;
					end
				endcase
			end
			CMD_NACK: begin
				case (stp_q)
					2'd0: ph_sda = 1'b1;
					2'd1: ph_scl = 1'b1;
					2'd2: ph_scl = 1'b0;
					default: begin
						ph_sda  = 1'b0;
						ph_last = 1'b1;
					end
				endcase
			end
			default: ph_last = 1'b1;
		endcase
	end

	assign fire = active_q && (!ovalid_q || phase.ready);
	assign pop  = q_valid && (!active_q || (fire && ph_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			stp_q    <= '0;
			bit_q    <= '0;
			sub_q    <= '0;
			scl_q    <= 1'b1;
			sda_q    <= 1'b1;
			ovalid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
				stp_q    <= '0;
				bit_q    <= '0;
				sub_q    <= '0;
			end else if (fire && ph_last) begin
				active_q <= 1'b0;
			end else if (fire) begin
				if (loop_cmd && stp_q != 2'd0) begin
					if (sub_q == sub_end) begin
						sub_q <= '0;
						bit_q <= bit_q + 1'b1;
					end else begin
						sub_q <= sub_q + 1'b1;
					end
				end else begin
					stp_q <= stp_q + 1'b1;
				end
			end
			if (fire) begin
				scl_q    <= ph_scl;
				sda_q    <= ph_sda;
				ovalid_q <= 1'b1;
			end else if (phase.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_item;
		end
		if (fire) begin
			oscl_q  <= ph_scl;
			osda_q  <= ph_sda;
			ohold_q <= ph_hold;
			osmp_q  <= ph_smp;
			orxd_q  <= ph_rxd;
			oack_q  <= ph_ack;
			olast_q <= ph_last;
		end
	end

	assign phase.valid   = ovalid_q;
	assign phase.scl     = oscl_q;
	assign phase.sda     = osda_q;
	assign phase.hold_us = ohold_q;
	assign phase.sampled = osmp_q;
	assign phase.rx_data = orxd_q;
	assign phase.ack     = oack_q;
	assign phase.last    = olast_q;

	`SCCB_ASSERT_IMPL(a_smp_scl_high, clk, arst_n, ovalid_q && osmp_q, oscl_q, "sample with scl low")
	`SCCB_ASSERT_IMPL(a_rx_on_last, clk, arst_n, ovalid_q && !olast_q, orxd_q == 8'd0 && !oack_q, "read data before last word")
	`SCCB_ASSERT_NEXT(a_done_idle, clk, arst_n, fire && ph_last && !q_valid, !active_q, "sequencer busy after last phase")

endmodule

// ===== rtl/sccb_master_bit_sequencer.sv =====
// SCCB bit sequencer: takes one bus command per word (start, stop, write byte, read byte,
// read ack, send not-acknowledge) and returns the pin phases it causes, one word per phase
// with the SCL/SDA levels, the hold time in microseconds and a sample flag; read data and
// ack arrive on the word marked last. A command yields 3 (stop, read ack), 4 (start,
// not-acknowledge), 17 (read byte) or 25 (write byte) words, set by the phase counter of
// the back end, which stalls while the phase output is not ready; the front end takes
// a new command every cycle while its two-entry queue has room, so queued commands run
// back to back. Unused codes are taken and produce no words. Line levels reset to released.
module sccb_master_bit_sequencer import sccb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	sccb_cmd_if.sink     cmd,
	sccb_phase_if.source phase
);

	logic      push;
	cmd_item_t push_item;
	logic      full;
	logic      pop;
	logic      q_valid;
	cmd_item_t q_item;

	sccb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	sccb_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	sccb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.pop     (pop),
		.phase   (phase)
	);

endmodule
